// ===== design/swpb_pkg.sv =====
// Shared types and constants for the sliding-window packet slot buffer.
package swpb_pkg;

  localparam int WindowDepth = 16;
  localparam int MaxPacketBytes = 1024;
  localparam int SeqBits = 32;
  localparam int IdxBits = $clog2(WindowDepth);
  localparam int OffBits = $clog2(MaxPacketBytes);
  localparam int LenBits = OffBits + 1;
  localparam int MemBits = IdxBits + OffBits;
  localparam int QueueDepth = 2;

  localparam logic [2:0] CmdWrite = 3'd0;
  localparam logic [2:0] CmdRead  = 3'd1;
  localparam logic [2:0] CmdSlide = 3'd2;
  localparam logic [2:0] CmdMove  = 3'd3;
  localparam logic [2:0] CmdQuery = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StOutWin = 2'd1;
  localparam logic [1:0] StNoEnt  = 2'd2;
  localparam logic [1:0] StOffBig = 2'd3;

  localparam logic CfgWindowSize = 1'b0;
  localparam logic CfgEntryBytes = 1'b1;

  // One command as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [SeqBits-1:0] seq;
    logic [OffBits-1:0] off;
    logic [7:0]         data;
    logic               last;
    logic [IdxBits-1:0] idx;
  } cmd_t;

endpackage

// ===== design/swpb_front.sv =====
// Front end: accepts a command and finds its slot index (sequence mod window size).
module swpb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_command,
  input  logic [swpb_pkg::SeqBits-1:0]  in_seq_number,
  input  logic [swpb_pkg::OffBits-1:0]  in_byte_offset,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last,
  input  logic [4:0]                    ws,
  input  logic                          q_full,
  output logic                          q_push,
  output swpb_pkg::cmd_t                q_data
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_MOD  = 2'b10
  } fstate_t;

  fstate_t                              state_r, state_nxt;
  swpb_pkg::cmd_t                       cmd_r, cmd_nxt;
  logic [swpb_pkg::SeqBits-1:0]         rem_r, rem_nxt;
  logic [5:0]                           bit_r, bit_nxt;
  logic [swpb_pkg::SeqBits:0]           trial;

  assign busy = (state_r != F_IDLE);
  // restoring remainder: one sequence bit per cycle
  assign trial = {rem_r, cmd_r.seq[bit_r[4:0]]} - {{(swpb_pkg::SeqBits-4){1'b0}}, ws};

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    q_push    = 1'b0;
    q_data    = cmd_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          cmd_nxt.cmd  = in_command;
          cmd_nxt.seq  = in_seq_number;
          cmd_nxt.off  = in_byte_offset;
          cmd_nxt.data = in_data_byte;
          cmd_nxt.last = in_last;
          rem_nxt      = '0;
          bit_nxt      = 6'(swpb_pkg::SeqBits - 1);
          state_nxt    = F_MOD;
        end
      end
      F_MOD: begin
        if (!bit_r[5]) begin
          if (!trial[swpb_pkg::SeqBits])
            rem_nxt = trial[swpb_pkg::SeqBits-1:0];
          else
            rem_nxt = {rem_r[swpb_pkg::SeqBits-2:0], cmd_r.seq[bit_r[4:0]]};
          bit_nxt = bit_r - 6'd1;
        end else if (!q_full) begin
          q_data.idx = rem_r[swpb_pkg::IdxBits-1:0];
          q_push     = 1'b1;
          state_nxt  = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
  end

endmodule

// ===== design/swpb_queue.sv =====
// Short FIFO of classified commands between front and back end.
module swpb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  swpb_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output swpb_pkg::cmd_t pop_data
);

  swpb_pkg::cmd_t mem_r [swpb_pkg::QueueDepth];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full      = (cnt_r == 2'(swpb_pkg::QueueDepth));
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== design/swpb_back.sv =====
// Back end: executes commands against slot state and packet memory, emits results.
module swpb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  swpb_pkg::cmd_t                q_data,
  output logic                          q_pop,
  input  logic [4:0]                    ws,
  input  logic [10:0]                   eb,
  output logic                          idle,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_read_byte,
  output logic [10:0]                   out_packet_length,
  output logic                          out_has_entry,
  output logic                          out_window_open,
  output logic [31:0]                   out_lower_edge,
  output logic [31:0]                   out_current_position
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_EXEC  = 3'b010,
    B_SLIDE = 3'b100
  } bstate_t;

  localparam int SB = swpb_pkg::SeqBits;
  localparam int IB = swpb_pkg::IdxBits;

  bstate_t                     state_r, state_nxt;
  swpb_pkg::cmd_t              c_r;
  logic [swpb_pkg::WindowDepth-1:0] valid_r;
  logic [SB-1:0]               sseq_r [swpb_pkg::WindowDepth];
  logic [10:0]                 slen_r [swpb_pkg::WindowDepth];
  logic [7:0]                  mem [2**swpb_pkg::MemBits];
  logic [7:0]                  mem_q;
  logic [SB-1:0]               lower_r, cur_r;
  logic [IB-1:0]               walk_r;
  logic [4:0]                  left_r;
  logic [SB:0]                 upper;
  logic                        inwin, holds;
  logic [SB:0]                 span;
  logic [IB:0]                 wrap_idx;
  logic [IB-1:0]               start_idx;

  assign upper = {1'b0, lower_r} + {{(SB-4){1'b0}}, ws};
  assign inwin = (c_r.seq >= lower_r) && ({1'b0, c_r.seq} < upper);
  assign holds = valid_r[c_r.idx] && (sseq_r[c_r.idx] == c_r.seq);
  assign span  = {1'b0, c_r.seq} - {1'b0, lower_r};
  assign idle  = (state_r == B_IDLE) && !q_valid;
  assign q_pop = (state_r == B_IDLE) && q_valid;

  // lower_r mod ws found by stepping: keep walk index as the slot to clear
  assign wrap_idx = {1'b0, walk_r} + {{IB{1'b0}}, 1'b1};

  // old lower edge slot: step back from the new edge's slot by the span (span < ws)
  assign start_idx = ({1'b0, c_r.idx} >= span[IB:0]) ? c_r.idx - span[IB-1:0]
                   : c_r.idx + ws[IB-1:0] - span[IB-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (q_valid) state_nxt = B_EXEC;
      B_EXEC:  if (c_r.cmd == swpb_pkg::CmdSlide && c_r.seq > lower_r) state_nxt = B_SLIDE;
               else state_nxt = B_IDLE;
      B_SLIDE: if (left_r <= 5'd1) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // packet memory: read registered, one port write
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && q_valid)
      mem_q <= mem[{q_data.idx, q_data.off}];
    if (state_r == B_EXEC && c_r.cmd == swpb_pkg::CmdWrite && inwin &&
        {1'b0, c_r.off} < eb)
      mem[{c_r.idx, c_r.off}] <= c_r.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      valid_r    <= '0;
      lower_r    <= '0;
      cur_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (q_valid) c_r <= q_data;
        end
        B_EXEC: begin
          out_status        <= swpb_pkg::StOk;
          out_read_byte     <= '0;
          out_packet_length <= '0;
          out_has_entry     <= holds;
          out_window_open   <= upper > {1'b0, cur_r};
          out_lower_edge    <= lower_r;
          out_current_position <= cur_r;
          out_strobe        <= 1'b1;
          case (c_r.cmd)
            swpb_pkg::CmdWrite: begin
              if (!inwin) out_status <= swpb_pkg::StOutWin;
              else if ({1'b0, c_r.off} >= eb) out_status <= swpb_pkg::StOffBig;
              else begin
                valid_r[c_r.idx] <= c_r.last;
                if (c_r.last) begin
                  sseq_r[c_r.idx] <= c_r.seq;
                  slen_r[c_r.idx] <= {1'b0, c_r.off} + 11'd1;
                end
                out_has_entry <= c_r.last;
              end
            end
            swpb_pkg::CmdRead: begin
              if (!inwin) out_status <= swpb_pkg::StOutWin;
              else if (!holds) out_status <= swpb_pkg::StNoEnt;
              else if ({1'b0, c_r.off} >= slen_r[c_r.idx]) out_status <= swpb_pkg::StOffBig;
              else begin
                out_read_byte     <= mem_q;
                out_packet_length <= slen_r[c_r.idx];
              end
            end
            swpb_pkg::CmdSlide: begin
              lower_r        <= c_r.seq;
              out_lower_edge <= c_r.seq;
              out_window_open <= ({1'b0, c_r.seq} + {{(SB-4){1'b0}}, ws}) > {1'b0, cur_r};
              // a span of a full window clears every slot in use, starting anywhere
              walk_r <= (span >= {{(SB-4){1'b0}}, ws}) ? '0 : start_idx;
              left_r <= (span >= {{(SB-4){1'b0}}, ws}) ? ws : span[4:0];
              if (c_r.seq > lower_r) out_strobe <= 1'b0;
            end
            swpb_pkg::CmdMove: begin
              if ({1'b0, c_r.seq} > upper) out_status <= swpb_pkg::StOutWin;
              else begin
                cur_r <= c_r.seq;
                out_current_position <= c_r.seq;
                out_window_open <= upper > {1'b0, c_r.seq};
              end
            end
            default: ;
          endcase
        end
        B_SLIDE: begin
          valid_r[walk_r] <= 1'b0;
          walk_r <= (wrap_idx >= {1'b0, ws[IB-1:0]} && ws != 5'(swpb_pkg::WindowDepth)) ||
                    wrap_idx[IB] ? '0 : wrap_idx[IB-1:0];
          left_r <= left_r - 5'd1;
          if (left_r <= 5'd1) begin
            out_strobe        <= 1'b1;
            out_status        <= swpb_pkg::StOk;
            out_read_byte     <= '0;
            out_packet_length <= '0;
            out_has_entry     <= (valid_r & ~(16'(1) << walk_r)) != 0 &&
                                 ((valid_r[c_r.idx] && c_r.idx != walk_r) &&
                                  sseq_r[c_r.idx] == c_r.seq);
            out_lower_edge    <= lower_r;
            out_current_position <= cur_r;
            out_window_open   <= upper > {1'b0, cur_r};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sliding_window_pdu_buffer.sv =====
// Sliding-window packet slot buffer: one command in, one result strobe out per command.
// A command is accepted at the edge where start is high and busy is low; its
// out_strobe follows after the front end's bit-serial remainder finds the slot
// index and pushes the command into the queue, and the back end pops it and then
// executes it. A forward slide that passes over n slots (at most the window
// size) adds a clearing step for each of those slots before the strobe.
// busy stays high until the command is pushed into the queue, and the back end
// always finishes a command before the front end can push the next one.
// Results cannot be stalled and appear for exactly one cycle on out_strobe.
// Configuration writes are taken only while no command is in flight.
module sliding_window_pdu_buffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_seq_number,
  input  logic [9:0]  in_byte_offset,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [10:0] out_packet_length,
  output logic        out_has_entry,
  output logic        out_window_open,
  output logic [31:0] out_lower_edge,
  output logic [31:0] out_current_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  logic [4:0]     ws_r, ws_eff;
  logic [10:0]    eb_r, eb_eff;
  logic           q_full, q_push, q_pop, q_ne, fbusy, bidle;
  swpb_pkg::cmd_t q_in, q_out;

  // register writes wait until front, queue and back end are all empty
  assign cfg_ready = !fbusy && bidle;
  assign busy = fbusy;
  // effective register values
  assign ws_eff = (ws_r == 5'd0) ? 5'd1 :
                  (ws_r > 5'(swpb_pkg::WindowDepth) ? 5'(swpb_pkg::WindowDepth) : ws_r);
  assign eb_eff = (eb_r == 11'd0) ? 11'd1 :
                  (eb_r > 11'(swpb_pkg::MaxPacketBytes) ? 11'(swpb_pkg::MaxPacketBytes) : eb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= 5'(swpb_pkg::WindowDepth);
      eb_r <= 11'(swpb_pkg::MaxPacketBytes);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swpb_pkg::CfgWindowSize: ws_r <= cfg_data[4:0];
        swpb_pkg::CfgEntryBytes: eb_r <= cfg_data;
        default: ;
      endcase
    end
  end

  swpb_front u_front (
    .clk, .rst_n, .start, .busy(fbusy), .in_command, .in_seq_number,
    .in_byte_offset, .in_data_byte, .in_last, .ws(ws_eff),
    .q_full, .q_push, .q_data(q_in)
  );

  swpb_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .pop_data(q_out)
  );

  swpb_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .q_data(q_out), .q_pop, .ws(ws_eff), .eb(eb_eff),
    .idle(bidle), .out_strobe, .out_status, .out_read_byte, .out_packet_length,
    .out_has_entry, .out_window_open, .out_lower_edge, .out_current_position
  );

endmodule
